### hdl/two_key_mode_selector_assert.svh
// ----------------------------------------------------------------------------
// two_key_mode_selector_assert.svh
// assertion macros used by the mode selector checker
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_MODE_SELECTOR_ASSERT_SVH
`define TWO_KEY_MODE_SELECTOR_ASSERT_SVH

// clocked assertion, muted while reset is asserted
`define TKMS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define TKMS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tkms_pkg.sv
// ----------------------------------------------------------------------------
// tkms_pkg
// types, constants and helper functions of the two-key mode selector
// ----------------------------------------------------------------------------
package tkms_pkg;

    localparam int CNT_W  = 16;
    localparam int MODE_W = 3;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam cnt_t  CNT_MAX    = '1;
    localparam mode_t MODE_FIRST = 3'd1;
    localparam mode_t MODE_LAST  = 3'd4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRESS_MIN   = 2'd0,
        CFG_PRESS_MAX   = 2'd1,
        CFG_AUTO_PERIOD = 2'd2
    } cfg_idx_t;

    localparam cnt_t PRESS_MIN_RST   = 16'd4;
    localparam cnt_t PRESS_MAX_RST   = 16'd200;
    localparam cnt_t AUTO_PERIOD_RST = 16'd1000;

    // classification of a key on this tick
    typedef struct packed {
        logic short_rel;
        logic long_rel;
    } key_press_t;

    typedef struct packed {
        logic  switch_led_toggle;
        logic  down_led_toggle;
        logic  up_led_toggle;
        logic  manual_on;
        mode_t mode_now;
        logic  line_c;
        logic  line_b;
        logic  line_a;
    } tkms_result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + cnt_t'(1);
    endfunction

    function automatic mode_t mode_up(input mode_t m);
        mode_up = (m >= MODE_LAST) ? MODE_FIRST : m + mode_t'(1);
    endfunction

    function automatic mode_t mode_down(input mode_t m);
        mode_down = (m <= MODE_FIRST) ? MODE_LAST : m - mode_t'(1);
    endfunction

endpackage

### hdl/tkms_key_timer.sv
// ----------------------------------------------------------------------------
// tkms_key_timer
// hold counter of one key and classification of its release
// ----------------------------------------------------------------------------
module tkms_key_timer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                key_down,
    input  tkms_pkg::cnt_t      press_min,
    input  tkms_pkg::cnt_t      press_max,
    output tkms_pkg::key_press_t press
);
    import tkms_pkg::*;

    cnt_t hold_reg;
    cnt_t hold_next;

    always_comb begin
        hold_next       = key_down ? sat_inc(hold_reg) : '0;
        press.short_rel = !key_down && (hold_reg >= press_min) && (hold_reg <= press_max);
        press.long_rel  = !key_down && (hold_reg > press_max);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (advance) begin
            hold_reg <= hold_next;
        end
    end

endmodule

### hdl/tkms_mode_core.sv
// ----------------------------------------------------------------------------
// tkms_mode_core
// manual/auto flag, mode register and auto advance counter
// ----------------------------------------------------------------------------
module tkms_mode_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  tkms_pkg::key_press_t   press_one,
    input  tkms_pkg::key_press_t   press_two,
    input  tkms_pkg::cnt_t         auto_period,
    output tkms_pkg::tkms_result_t result
);
    import tkms_pkg::*;

    logic  manual_reg;
    logic  manual_next;
    mode_t mode_reg;
    mode_t mode_next;
    cnt_t  auto_count_reg;
    cnt_t  auto_count_next;

    logic  up;
    logic  down;
    logic  sw;
    mode_t mode_k1;
    mode_t mode_k2;
    cnt_t  cnt_k1;
    cnt_t  cnt_inc;

    always_comb begin
        // key one first
        up      = press_one.short_rel && manual_reg;
        sw      = !up && press_one.long_rel;
        manual_next = sw ? !manual_reg : manual_reg;
        cnt_k1  = (sw && manual_reg) ? '0 : auto_count_reg;
        if (up) begin
            mode_k1 = mode_up(mode_reg);
        end else if (sw) begin
            mode_k1 = MODE_FIRST;
        end else begin
            mode_k1 = mode_reg;
        end

        // then key two, seeing the updated flag
        down    = press_two.short_rel && manual_next;
        mode_k2 = down ? mode_down(mode_k1) : mode_k1;

        // then the auto tick
        cnt_inc         = sat_inc(cnt_k1);
        auto_count_next = cnt_k1;
        mode_next       = mode_k2;
        if (!manual_next) begin
            if (cnt_inc >= auto_period) begin
                auto_count_next = '0;
                mode_next       = mode_up(mode_k2);
            end else begin
                auto_count_next = cnt_inc;
            end
        end

        result.line_a            = (mode_next == 3'd4);
        result.line_b            = (mode_next == 3'd1) || (mode_next == 3'd4);
        result.line_c            = (mode_next == 3'd2);
        result.mode_now          = mode_next;
        result.manual_on         = manual_next;
        result.up_led_toggle     = up;
        result.down_led_toggle   = down;
        result.switch_led_toggle = sw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg     <= 1'b0;
            mode_reg       <= MODE_FIRST;
            auto_count_reg <= '0;
        end else if (advance) begin
            manual_reg     <= manual_next;
            mode_reg       <= mode_next;
            auto_count_reg <= auto_count_next;
        end
    end

endmodule

### hdl/two_key_mode_selector.sv
// ----------------------------------------------------------------------------
// two_key_mode_selector
// two-key short/long press mode selector with automatic stepping
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one scan tick carrying the two key levels.
// For every request exactly one result leaves on the m_ channel: the decoded
// drive lines, the mode 1..4, the manual flag and three LED toggle pulses.
// The state update is done in the cycle the request is taken and the result
// sits in the output register on the next cycle.
// Throughput is one request per cycle while m_tready stays high; the single
// output register is the only stage, so s_tready is high whenever that
// register is empty or is being drained in the same cycle. A stalled receiver
// holds m_tdata and, with it, back-pressures the input one register deep.
// The cfg_ channel writes the shortest short-press hold (0), the longest
// short-press hold (1) and the auto period (2); it is always ready, and
// writes are meant for times when no tick is in flight.
// Synchronous reset (aresetn low) empties the output register, clears the
// hold and auto counters, selects auto mode and mode 1, and restores the
// register defaults 4, 200 and 1000.
// ----------------------------------------------------------------------------
module two_key_mode_selector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] key_one_down, [1] key_two_down
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] line_a, [1] line_b, [2] line_c, [5:3] mode_now, [6] manual_on,
    // [7] up_led_toggle, [8] down_led_toggle, [9] switch_led_toggle
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import tkms_pkg::*;

    cnt_t press_min_reg;
    cnt_t press_max_reg;
    cnt_t auto_period_reg;

    logic         m_tvalid_reg;
    logic         m_tvalid_next;
    tkms_result_t m_result_reg;

    logic         s_fire;
    key_press_t   press_one;
    key_press_t   press_two;
    tkms_result_t result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_min_reg   <= PRESS_MIN_RST;
            press_max_reg   <= PRESS_MAX_RST;
            auto_period_reg <= AUTO_PERIOD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRESS_MIN:   press_min_reg   <= cfg_data;
                CFG_PRESS_MAX:   press_max_reg   <= cfg_data;
                CFG_AUTO_PERIOD: auto_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tkms_key_timer u_key_one (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_fire),
        .key_down  (s_tdata[0]),
        .press_min (press_min_reg),
        .press_max (press_max_reg),
        .press     (press_one)
    );

    tkms_key_timer u_key_two (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_fire),
        .key_down  (s_tdata[1]),
        .press_min (press_min_reg),
        .press_max (press_max_reg),
        .press     (press_two)
    );

    tkms_mode_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s_fire),
        .press_one   (press_one),
        .press_two   (press_two),
        .auto_period (auto_period_reg),
        .result      (result)
    );

    always_comb begin
        if (s_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_result_reg};

endmodule

### hdl/tkms_checker.sv
// ----------------------------------------------------------------------------
// tkms_checker
// port-level checks of the two-key mode selector, bound to the top level
// ----------------------------------------------------------------------------
`include "two_key_mode_selector_assert.svh"

module tkms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `TKMS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid,
        "output valid after reset")

    `TKMS_ASSERT(a_stall_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
        "result changed while stalled")

    `TKMS_ASSERT(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready |-> s_tready,
        "input blocked with free output")

    `TKMS_ASSERT(a_mode_range, aclk, aresetn,
        m_tvalid |-> m_tdata[5:3] != 3'd0 && m_tdata[5:3] <= 3'd4,
        "mode out of range")

    `TKMS_ASSERT(a_step_manual, aclk, aresetn,
        m_tvalid && (m_tdata[7] || m_tdata[8]) |-> m_tdata[6],
        "mode step outside manual mode")

endmodule

bind two_key_mode_selector tkms_checker u_tkms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/two_key_mode_selector_tb.sv
// ----------------------------------------------------------------------------
// two_key_mode_selector_tb
// self-checking bench for the two-key short/long press mode selector
// ----------------------------------------------------------------------------
// A short table of scan ticks runs first. Its rows after reset, at the first
// auto advance and at the manual/auto switches carry typed-in results. All
// other rows, and the press sequences that follow, are checked against a
// behavioral copy of the selector kept inside the bench. Register settings
// change between phases while the block is idle. The last phase stays in
// manual mode with the short-press window reaching the counter limit.
// ----------------------------------------------------------------------------
module two_key_mode_selector_tb;
    import tkms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    two_key_mode_selector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // selector state as the bench predicts it
    cnt_t  held_one   = '0;
    cnt_t  held_two   = '0;
    logic  in_manual  = 1'b0;
    mode_t mode_q     = MODE_FIRST;
    cnt_t  auto_ticks = '0;
    cnt_t  short_min  = PRESS_MIN_RST;
    cnt_t  short_max  = PRESS_MAX_RST;
    cnt_t  auto_len   = AUTO_PERIOD_RST;

    tkms_result_t pending_results [$];
    tkms_result_t want, got;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned ticks_sent  = 0;
    int unsigned errors      = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_offs_asked = 0;
    int unsigned hold_offs_done  = 0;
    int unsigned hold_off_left   = 0;

    // fields from msb: switch, down, up, manual, mode, line_c, line_b, line_a
    localparam tkms_result_t RES_AUTO_M1 =
        tkms_result_t'{1'b0, 1'b0, 1'b0, 1'b0, 3'd1, 1'b0, 1'b1, 1'b0};
    localparam tkms_result_t RES_AUTO_M2 =
        tkms_result_t'{1'b0, 1'b0, 1'b0, 1'b0, 3'd2, 1'b1, 1'b0, 1'b0};
    localparam tkms_result_t RES_TO_MANUAL =
        tkms_result_t'{1'b1, 1'b0, 1'b0, 1'b1, 3'd1, 1'b0, 1'b1, 1'b0};
    localparam tkms_result_t RES_TO_AUTO =
        tkms_result_t'{1'b1, 1'b0, 1'b0, 1'b0, 3'd1, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        logic         k1;
        logic         k2;
        logic         typed;
        tkms_result_t res;
    } tick_row_t;

    // run with short-press window 1..3 and auto period 3
    tick_row_t tick_rows [25] = '{
        '{1'b0, 1'b0, 1'b1, RES_AUTO_M1},
        '{1'b0, 1'b0, 1'b1, RES_AUTO_M1},
        '{1'b0, 1'b0, 1'b1, RES_AUTO_M2},   // first auto advance
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // short press ignored in auto
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b1, RES_TO_MANUAL},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // step up
        '{1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // step down
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // up and down in one tick
        '{1'b0, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // down wraps 1 -> 4
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},            // up wraps 4 -> 1
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b1, RES_TO_AUTO}    // key two long press does nothing
    };

    task automatic next_selector_output(input logic k1, input logic k2,
                                        output tkms_result_t r);
        logic up_p, dn_p, sw_p;
        up_p = 1'b0;
        dn_p = 1'b0;
        sw_p = 1'b0;
        if (k1) begin
            if (held_one != CNT_MAX) held_one = held_one + cnt_t'(1);
        end else begin
            if (in_manual && held_one >= short_min && held_one <= short_max) begin
                up_p   = 1'b1;
                mode_q = (mode_q >= MODE_LAST) ? MODE_FIRST : mode_q + mode_t'(1);
            end else if (held_one > short_max) begin
                sw_p = 1'b1;
                if (in_manual) begin
                    in_manual  = 1'b0;
                    auto_ticks = '0;
                end else begin
                    in_manual = 1'b1;
                end
                mode_q = MODE_FIRST;
            end
            held_one = '0;
        end
        if (k2) begin
            if (held_two != CNT_MAX) held_two = held_two + cnt_t'(1);
        end else begin
            if (in_manual && held_two >= short_min && held_two <= short_max) begin
                dn_p   = 1'b1;
                mode_q = (mode_q <= MODE_FIRST) ? MODE_LAST : mode_q - mode_t'(1);
            end
            held_two = '0;
        end
        if (!in_manual) begin
            if (auto_ticks != CNT_MAX) auto_ticks = auto_ticks + cnt_t'(1);
            if (auto_ticks >= auto_len) begin
                auto_ticks = '0;
                mode_q = (mode_q >= MODE_LAST) ? MODE_FIRST : mode_q + mode_t'(1);
            end
        end
        r = '0;
        case (mode_q)
            MODE_FIRST: r.line_b = 1'b1;
            3'd2:       r.line_c = 1'b1;
            MODE_LAST: begin
                r.line_a = 1'b1;
                r.line_b = 1'b1;
            end
            default: ;
        endcase
        r.mode_now          = mode_q;
        r.manual_on         = in_manual;
        r.up_led_toggle     = up_p;
        r.down_led_toggle   = dn_p;
        r.switch_led_toggle = sw_p;
    endtask

    // one scan tick request; the expectation is queued when it is taken
    task automatic send_tick(input logic k1, input logic k2,
                             input logic typed, input tkms_result_t typed_res);
        tkms_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, k2, k1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        next_selector_output(k1, k2, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
        ticks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic program_regs(input cnt_t s_val, input cnt_t l_val, input cnt_t p_val);
        cfg_idx_t regs [3];
        cnt_t     vals [3];
        regs = '{CFG_PRESS_MIN, CFG_PRESS_MAX, CFG_AUTO_PERIOD};
        vals = '{s_val, l_val, p_val};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (regs[i])
                CFG_PRESS_MIN:   short_min = vals[i];
                CFG_PRESS_MAX:   short_max = vals[i];
                CFG_AUTO_PERIOD: auto_len  = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // hold keys for len ticks with a little chatter, then release both
    task automatic hold_and_release(input logic k1, input logic k2, input int len);
        repeat (len) begin
            send_tick(k1 | ($urandom_range(0, 7) == 0),
                      k2 | ($urandom_range(0, 7) == 0), 1'b0, '0);
        end
        send_tick(1'b0, 1'b0, 1'b0, '0);
    endtask

    task automatic random_presses(input int unsigned n);
        int unsigned target;
        int          span;
        int          len;
        int unsigned kind;
        target = ticks_sent + n;
        while (ticks_sent < target) begin
            span = (short_max > 30) ? 33 : int'(short_max) + 3;
            len  = $urandom_range(0, span);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (kind < 6) begin
                hold_and_release(1'b1, 1'b0, len);
            end else if (kind < 9) begin
                hold_and_release(1'b0, 1'b1, len);
            end else begin
                hold_and_release(1'b1, 1'b1, len);
            end
        end
    endtask

    task automatic steer_to_manual(input logic wanted);
        while (in_manual != wanted) hold_and_release(1'b1, 1'b0, int'(short_max) + 1);
    endtask

    task automatic check_field(input string name, input logic [5:0] exp_v,
                               input logic [5:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result 0x%h, expected none", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                got  = tkms_result_t'(m_tdata[9:0]);
                check_field("line_a", 6'(want.line_a), 6'(got.line_a));
                check_field("line_b", 6'(want.line_b), 6'(got.line_b));
                check_field("line_c", 6'(want.line_c), 6'(got.line_c));
                check_field("mode_now", 6'(want.mode_now), 6'(got.mode_now));
                check_field("manual_on", 6'(want.manual_on), 6'(got.manual_on));
                check_field("up_led_toggle", 6'(want.up_led_toggle),
                            6'(got.up_led_toggle));
                check_field("down_led_toggle", 6'(want.down_led_toggle),
                            6'(got.down_led_toggle));
                check_field("switch_led_toggle", 6'(want.switch_led_toggle),
                            6'(got.switch_led_toggle));
                check_field("tdata padding", '0, m_tdata[15:10]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_offs_done != hold_offs_asked) begin
            hold_offs_done++;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 23;
        rx_idle_pct = 77;
        program_regs(16'd1, 16'd3, 16'd3);
        foreach (tick_rows[i])
            send_tick(tick_rows[i].k1, tick_rows[i].k2, tick_rows[i].typed, tick_rows[i].res);
        drain();

        program_regs(16'd2, 16'd8, 16'd5);
        random_presses(40);
        hold_offs_asked++;
        random_presses(40);
        drain();   // sender waits for every result before going on
        random_presses(50);
        drain();

        tx_idle_pct = 77;
        rx_idle_pct = 23;
        program_regs(16'd1, 16'd1, 16'd1);
        random_presses(80);
        drain();
        // shortest short press above the longest: no hold is a short press
        program_regs(16'd6, 16'd3, 16'd5);
        random_presses(60);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(16'd3, 16'd12, 16'd7);
        random_presses(100);
        drain();

        // short-press window up to the counter limit: no hold is a long press
        program_regs(16'd1, 16'd2, 16'd4);
        steer_to_manual(1'b1);
        drain();
        program_regs(16'd2, CNT_MAX, 16'd4);
        random_presses(30);
        drain();

        repeat (10) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
